### rtl/core/mac_learning_bridge_defines.svh
// assertion macros for the bridge
`ifndef MAC_LEARNING_BRIDGE_DEFINES_SVH
`define MAC_LEARNING_BRIDGE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MLB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define MLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MLB_ASSERT(label, clk, rst_n, prop)
`define MLB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/mlb_pkg.sv
package mlb_pkg;
  localparam int unsigned NumPortsDef = 8;
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned MacW = 48;
  localparam int unsigned PortW = 3;
  localparam int unsigned MaskW = 8;
  localparam int unsigned GroupBit = 40;

  typedef enum logic [1:0] {
    FuncPacket = 2'd0,
    FuncAttach = 2'd1,
    FuncDetach = 2'd2,
    FuncNone   = 2'd3
  } func_e;
endpackage

### rtl/core/mlb_table.sv
`include "mac_learning_bridge_defines.svh"
module mlb_table import mlb_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [((TableEntries > 1) ? $clog2(TableEntries) : 1)-1:0] rd_idx_i,
  output logic                          rd_valid_o,
  output logic [MacW-1:0]               rd_mac_o,
  output logic [PortW-1:0]              rd_port_o,
  input  logic                          wr_en_i,
  input  logic [((TableEntries > 1) ? $clog2(TableEntries) : 1)-1:0] wr_idx_i,
  input  logic                          wr_valid_i,
  input  logic                          wr_mac_en_i,
  input  logic [MacW-1:0]               wr_mac_i,
  input  logic [PortW-1:0]              wr_port_i
);
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  logic [MacW-1:0]  mac_mem [TableEntries];
  logic [PortW-1:0] port_mem [TableEntries];
  logic [TableEntries-1:0] valid_q;
  logic [IdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_mac_en_i) mac_mem[wr_idx_i] <= wr_mac_i;
    if (wr_en_i) port_mem[wr_idx_i] <= wr_port_i;
    rd_mac_o  <= mac_mem[rd_idx_i];
    rd_port_o <= port_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      if (wr_en_i) valid_q[wr_idx_i] <= wr_valid_i;
      rd_idx_q <= rd_idx_i;
    end
  end

  // write in the same cycle as the read address seen here
  assign rd_valid_o = valid_q[rd_idx_q];

  `MLB_ASSERT(a_idx_range, clk_i, rst_ni, 32'(wr_idx_i) < TableEntries || !wr_en_i)
endmodule

### rtl/core/mac_learning_bridge.sv
// packet: up to two scans of the table (source, then destination) through one compare unit
// detach: one flush walk of the table; attach: no table scan
// one transaction at a time: ready only in idle, so a new one waits until the last result is taken
// result held in an output register until taken
// reset (async, active low) clears all entry valid bits and port state at once
`include "mac_learning_bridge_defines.svh"
module mac_learning_bridge import mlb_pkg::*; #(
  parameter int unsigned NUM_PORTS     = NumPortsDef,
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [1:0]       func_i,
  input  logic [PortW-1:0] ingress_port_i,
  input  logic [MacW-1:0]  dst_mac_i,
  input  logic [MacW-1:0]  src_mac_i,
  input  logic             filter_pass_i,
  input  logic             port_is_tap_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [MaskW-1:0] forward_mask_o,
  output logic             dst_known_o,
  output logic             learned_o,
  output logic             moved_o,
  output logic             table_full_o
);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 2) + 1;
  localparam logic [2:0] StIdle = 3'd0, StSrc = 3'd1, StDst = 3'd2, StFlush = 3'd3,
                         StDone = 3'd4, StOut = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  func_e func_q;
  logic [PortW-1:0] port_q;
  logic [MacW-1:0] dst_q, src_q;
  logic pass_q;
  logic [7:0] active_q, tap_q;
  logic src_hit_q, free_q, dst_hit_q;
  logic [IdxW-1:0] src_idx_q, free_idx_q;
  logic [PortW-1:0] src_port_q, dst_port_q;
  logic [MaskW-1:0] mask_q;
  logic known_q, learned_q, moved_q, full_q;

  logic [IdxW-1:0] rd_idx, wr_idx;
  logic rd_valid, wr_en, wr_valid, wr_mac_en;
  logic [MacW-1:0] rd_mac, cmp_mac, wr_mac;
  logic [PortW-1:0] rd_port, wr_port;
  logic cmp_hit, scan_live, last_rd;
  logic [IdxW-1:0] scan_idx;
  logic [7:0] pbit, deliver, port_lim;

  mlb_table #(.TableEntries(TABLE_ENTRIES)) u_table (
    .clk_i, .rst_ni,
    .rd_idx_i(rd_idx), .rd_valid_o(rd_valid), .rd_mac_o(rd_mac), .rd_port_o(rd_port),
    .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_valid_i(wr_valid), .wr_mac_en_i(wr_mac_en),
    .wr_mac_i(wr_mac), .wr_port_i(wr_port)
  );

  // cnt counts issued reads; the table registers the read data, so it arrives in the cycle after the read
  assign rd_idx    = cnt_q[IdxW-1:0];
  assign last_rd   = cnt_q == CntW'(TABLE_ENTRIES);
  assign scan_live = cnt_q != '0;
  assign scan_idx  = IdxW'(cnt_q - CntW'(1));
  assign cmp_mac   = (state_q == StSrc) ? src_q : dst_q;
  assign cmp_hit   = rd_valid && (rd_mac == cmp_mac);
  assign pbit      = 8'(1) << port_q;
  assign deliver   = pass_q ? 8'hff : ~tap_q;
  for (genvar p = 0; p < 8; p++) begin : g_lim
    assign port_lim[p] = (p < NUM_PORTS);
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    wr_en = 1'b0; wr_idx = src_idx_q; wr_valid = 1'b1; wr_mac_en = 1'b0;
    wr_mac = src_q; wr_port = port_q;
    unique case (state_q)
      StIdle: if (valid_i) begin
        cnt_d = '0;
        state_d = StDone;
        if (32'(ingress_port_i) < NUM_PORTS) begin
          if (func_i == FuncDetach) state_d = StFlush;
          else if (func_i == FuncPacket && active_q[ingress_port_i])
            state_d = src_mac_i[GroupBit] ? StDst : StSrc;
        end
      end
      StSrc, StDst, StFlush: begin
        if (state_q == StFlush && scan_live && rd_valid && rd_port == port_q) begin
          wr_en = 1'b1; wr_idx = scan_idx; wr_valid = 1'b0; wr_port = rd_port;
        end
        if (cnt_q == CntW'(TABLE_ENTRIES)) begin
          cnt_d = '0;
          if (state_q == StSrc) begin
            state_d = dst_q[GroupBit] ? StDone : StDst;
            if (src_hit_q || (cmp_hit && scan_live)) begin
              wr_en = 1'b1;
              wr_idx = (src_hit_q) ? src_idx_q : scan_idx;
            end else if (free_q || !rd_valid) begin
              wr_en = 1'b1; wr_mac_en = 1'b1;
              wr_idx = free_q ? free_idx_q : scan_idx;
            end
          end else state_d = StDone;
        end else cnt_d = cnt_q + CntW'(1);
      end
      StDone: state_d = StOut;
      StOut: if (ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; active_q <= '0; tap_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      if (state_q == StIdle && valid_i && 32'(ingress_port_i) < NUM_PORTS) begin
        if (func_i == FuncAttach) begin
          active_q[ingress_port_i] <= 1'b1;
          tap_q[ingress_port_i] <= port_is_tap_i;
        end else if (func_i == FuncDetach) begin
          active_q[ingress_port_i] <= 1'b0;
          tap_q[ingress_port_i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && valid_i) begin
      func_q <= func_e'(func_i); port_q <= ingress_port_i;
      dst_q <= dst_mac_i; src_q <= src_mac_i; pass_q <= filter_pass_i;
      src_hit_q <= 1'b0; free_q <= 1'b0; dst_hit_q <= 1'b0;
      learned_q <= 1'b0; moved_q <= 1'b0; full_q <= 1'b0;
    end
    if ((state_q == StSrc || state_q == StDst) && scan_live) begin
      if (state_q == StSrc && cmp_hit && !src_hit_q) begin
        src_hit_q <= 1'b1; src_idx_q <= scan_idx; src_port_q <= rd_port;
      end
      if (state_q == StSrc && !rd_valid && !free_q) begin
        free_q <= 1'b1; free_idx_q <= scan_idx;
      end
      if (state_q == StDst && cmp_hit && !dst_hit_q) begin
        dst_hit_q <= 1'b1; dst_port_q <= (rd_port == port_q) ? rd_port : rd_port;
      end
    end
    if (state_q == StSrc && last_rd) begin
      if (src_hit_q || cmp_hit) moved_q <= (src_hit_q ? src_port_q : rd_port) != port_q;
      else if (free_q || !rd_valid) learned_q <= 1'b1;
      else full_q <= 1'b1;
    end
    if (state_q == StDone) begin
      known_q <= 1'b0; mask_q <= '0;
      if (func_q == FuncPacket && 32'(port_q) < NUM_PORTS && active_q[port_q]) begin
        known_q <= dst_hit_q;
        if (dst_hit_q) mask_q <= (dst_port_q == port_q) ? 8'h00
                                 : ((8'(1) << dst_port_q) & deliver & port_lim);
        else mask_q <= active_q & ~pbit & deliver & port_lim;
      end else begin
        learned_q <= 1'b0; moved_q <= 1'b0; full_q <= 1'b0;
      end
    end
  end

  assign ready_o        = state_q == StIdle;
  assign valid_o        = state_q == StOut;
  assign forward_mask_o = mask_q;
  assign dst_known_o    = known_q;
  assign learned_o      = learned_q;
  assign moved_o        = moved_q;
  assign table_full_o   = full_q;

  `MLB_ASSERT(a_one_flag, clk_i, rst_ni, !valid_o || $countones({learned_o, moved_o, table_full_o}) <= 1)
  `MLB_ASSERT(a_hs_excl, clk_i, rst_ni, !(ready_o && valid_o))
  `MLB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && !ready_i, valid_o && $stable(forward_mask_o))
endmodule
